@@ rtl/integer_alu_div_mod_pow_unit_assert.svh @@
// Assertion macros for the top level of the integer ALU.
`ifndef INTEGER_ALU_DIV_MOD_POW_UNIT_ASSERT_SVH
`define INTEGER_ALU_DIV_MOD_POW_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define IADP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define IADP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define IADP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IADP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/iadp_pkg.sv @@
// Package with payload types, microcode types and the control store of the integer ALU.
package iadp_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;
  localparam logic [2:0] OP_POW = 3'd5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               divide_by_zero;
  } out_item_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_ADD,
    U_SUB,
    U_MUL,
    U_DIV_INIT,
    U_DIV_STEP,
    U_DIV_FIX,
    U_POW_INIT,
    U_POW_STEP,
    U_POW_DONE,
    U_ZERO,
    U_DZ,
    U_POW_TRIV
  } uop_t;

  typedef enum logic [2:0] {
    C_NONE,
    C_DISPATCH,
    C_A_ZERO,
    C_B_ZERO,
    C_POW_TRIV,
    C_LOOP
  } cond_t;

  localparam logic [3:0] A_DISPATCH  = 4'd0;
  localparam logic [3:0] A_ADD       = 4'd1;
  localparam logic [3:0] A_SUB       = 4'd2;
  localparam logic [3:0] A_MUL       = 4'd3;
  localparam logic [3:0] A_DIV_CHKA  = 4'd4;
  localparam logic [3:0] A_DIV_CHKB  = 4'd5;
  localparam logic [3:0] A_DIV_INIT  = 4'd6;
  localparam logic [3:0] A_DIV_STEP  = 4'd7;
  localparam logic [3:0] A_DIV_FIX   = 4'd8;
  localparam logic [3:0] A_POW_CHK   = 4'd9;
  localparam logic [3:0] A_POW_INIT  = 4'd10;
  localparam logic [3:0] A_POW_STEP  = 4'd11;
  localparam logic [3:0] A_POW_DONE  = 4'd12;
  localparam logic [3:0] A_ZERO      = 4'd13;
  localparam logic [3:0] A_DZ        = 4'd14;
  localparam logic [3:0] A_POW_TRIV  = 4'd15;

  localparam logic [4:0] DIV_STEPS_M1 = 5'd31;
  localparam logic [4:0] POW_STEPS_M1 = 5'd30;

  typedef struct packed {
    uop_t       uop;
    cond_t      cond;
    logic [3:0] target;
    logic       done;
    logic       ld_cnt;
    logic [4:0] cnt_val;
  } ucode_t;

  typedef struct packed {
    logic       exec;
    logic       done;
    uop_t       uop;
  } ctrl_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       a_zero;
    logic       b_zero;
    logic       pow_triv;
  } status_t;

  function automatic ucode_t cw(uop_t uop, cond_t cond, logic [3:0] target,
                                logic done, logic ld_cnt, logic [4:0] cnt_val);
    ucode_t w;
    w.uop     = uop;
    w.cond    = cond;
    w.target  = target;
    w.done    = done;
    w.ld_cnt  = ld_cnt;
    w.cnt_val = cnt_val;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(logic [3:0] addr);
    ucode_t w;
    unique case (addr)
      A_DISPATCH: w = cw(U_NOP,      C_DISPATCH, A_DISPATCH, 1'b0, 1'b0, 5'd0);
      A_ADD:      w = cw(U_ADD,      C_NONE,     A_DISPATCH, 1'b1, 1'b0, 5'd0);
      A_SUB:      w = cw(U_SUB,      C_NONE,     A_DISPATCH, 1'b1, 1'b0, 5'd0);
      A_MUL:      w = cw(U_MUL,      C_NONE,     A_DISPATCH, 1'b1, 1'b0, 5'd0);
      A_DIV_CHKA: w = cw(U_NOP,      C_A_ZERO,   A_ZERO,     1'b0, 1'b0, 5'd0);
      A_DIV_CHKB: w = cw(U_NOP,      C_B_ZERO,   A_DZ,       1'b0, 1'b0, 5'd0);
      A_DIV_INIT: w = cw(U_DIV_INIT, C_NONE,     A_DISPATCH, 1'b0, 1'b1, DIV_STEPS_M1);
      A_DIV_STEP: w = cw(U_DIV_STEP, C_LOOP,     A_DIV_STEP, 1'b0, 1'b0, 5'd0);
      A_DIV_FIX:  w = cw(U_DIV_FIX,  C_NONE,     A_DISPATCH, 1'b1, 1'b0, 5'd0);
      A_POW_CHK:  w = cw(U_NOP,      C_POW_TRIV, A_POW_TRIV, 1'b0, 1'b0, 5'd0);
      A_POW_INIT: w = cw(U_POW_INIT, C_NONE,     A_DISPATCH, 1'b0, 1'b1, POW_STEPS_M1);
      A_POW_STEP: w = cw(U_POW_STEP, C_LOOP,     A_POW_STEP, 1'b0, 1'b0, 5'd0);
      A_POW_DONE: w = cw(U_POW_DONE, C_NONE,     A_DISPATCH, 1'b1, 1'b0, 5'd0);
      A_ZERO:     w = cw(U_ZERO,     C_NONE,     A_DISPATCH, 1'b1, 1'b0, 5'd0);
      A_DZ:       w = cw(U_DZ,       C_NONE,     A_DISPATCH, 1'b1, 1'b0, 5'd0);
      A_POW_TRIV: w = cw(U_POW_TRIV, C_NONE,     A_DISPATCH, 1'b1, 1'b0, 5'd0);
      default:    w = cw(U_ZERO,     C_NONE,     A_DISPATCH, 1'b1, 1'b0, 5'd0);
    endcase
    return w;
  endfunction

  function automatic logic [3:0] dispatch(logic [2:0] opcode);
    logic [3:0] addr;
    unique case (opcode)
      OP_ADD:  addr = A_ADD;
      OP_SUB:  addr = A_SUB;
      OP_MUL:  addr = A_MUL;
      OP_DIV:  addr = A_DIV_CHKA;
      OP_REM:  addr = A_DIV_CHKA;
      OP_POW:  addr = A_POW_CHK;
      default: addr = A_ZERO;
    endcase
    return addr;
  endfunction

endpackage

@@ rtl/iadp_seq.sv @@
// Microcode sequencer: step counter, loop counter, control store and conditional jumps.
module iadp_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             hold,
  input  iadp_pkg::status_t status,
  output iadp_pkg::ctrl_t   ctrl,
  output logic             busy
);
  import iadp_pkg::*;

  logic       busy_r, busy_nxt;
  logic [3:0] pc_r, pc_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  ucode_t     word;
  logic       take;
  logic       exec;
  logic [3:0] target;

  assign word = ucode_rom(pc_r);
  assign exec = busy_r && !(word.done && hold);

  always_comb begin
    unique case (word.cond)
      C_NONE:     take = 1'b0;
      C_DISPATCH: take = 1'b1;
      C_A_ZERO:   take = status.a_zero;
      C_B_ZERO:   take = status.b_zero;
      C_POW_TRIV: take = status.pow_triv;
      C_LOOP:     take = (cnt_r != 5'd0);
      default:    take = 1'b0;
    endcase
  end

  assign target = (word.cond == C_DISPATCH) ? dispatch(status.opcode) : word.target;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = A_DISPATCH;
    end else if (exec) begin
      if (word.done) begin
        busy_nxt = 1'b0;
        pc_nxt   = A_DISPATCH;
      end else begin
        pc_nxt = take ? target : pc_r + 4'd1;
      end
      if (word.ld_cnt) begin
        cnt_nxt = word.cnt_val;
      end else if (word.cond == C_LOOP) begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= A_DISPATCH;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign ctrl.exec = exec;
  assign ctrl.done = word.done;
  assign ctrl.uop  = word.uop;
  assign busy      = busy_r;

endmodule

@@ rtl/iadp_dp.sv @@
// Datapath of the integer ALU: operand registers, shift-subtract divider and power unit.
module iadp_dp (
  input  logic               clk,
  input  logic               load,
  input  iadp_pkg::in_item_t in_item,
  input  iadp_pkg::ctrl_t    ctrl,
  output iadp_pkg::status_t  status,
  output iadp_pkg::out_item_t res_item
);
  import iadp_pkg::*;

  logic [2:0]  op_r;
  logic [31:0] a_r, b_r;
  logic [31:0] x_r, y_r, z_r;
  logic [32:0] trial;
  logic        fits;
  logic [31:0] mag_a, mag_b;
  logic [31:0] prod_ab, prod_xz, prod_zz;
  logic [31:0] res_nxt;
  logic        dz_nxt;

  assign mag_a   = a_r[31] ? (32'd0 - a_r) : a_r;
  assign mag_b   = b_r[31] ? (32'd0 - b_r) : b_r;
  assign trial   = {x_r, y_r[31]};
  assign fits    = (trial >= {1'b0, z_r});
  assign prod_ab = a_r * b_r;
  assign prod_xz = x_r * z_r;
  assign prod_zz = z_r * z_r;

  always_ff @(posedge clk) begin
    if (load) begin
      op_r <= in_item.opcode;
      a_r  <= in_item.operand_a;
      b_r  <= in_item.operand_b;
    end else if (ctrl.exec) begin
      unique case (ctrl.uop)
        U_DIV_INIT: begin
          x_r <= 32'd0;
          y_r <= mag_a;
          z_r <= mag_b;
        end
        U_DIV_STEP: begin
          x_r <= fits ? 32'(trial - {1'b0, z_r}) : trial[31:0];
          y_r <= {y_r[30:0], fits};
        end
        U_POW_INIT: begin
          x_r <= 32'd1;
          y_r <= b_r;
          z_r <= a_r;
        end
        U_POW_STEP: begin
          if (y_r[0]) begin
            x_r <= prod_xz;
          end
          z_r <= prod_zz;
          y_r <= {1'b0, y_r[31:1]};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_nxt = 32'd0;
    dz_nxt  = 1'b0;
    unique case (ctrl.uop)
      U_ADD:      res_nxt = a_r + b_r;
      U_SUB:      res_nxt = a_r - b_r;
      U_MUL:      res_nxt = prod_ab;
      U_DIV_FIX: begin
        if (op_r == OP_DIV) begin
          res_nxt = (a_r[31] ^ b_r[31]) ? (32'd0 - y_r) : y_r;
        end else begin
          res_nxt = a_r[31] ? (32'd0 - x_r) : x_r;
        end
      end
      U_POW_DONE: res_nxt = x_r;
      U_DZ:       dz_nxt  = 1'b1;
      U_POW_TRIV: res_nxt = (b_r == 32'd0) ? 32'd1 : ((a_r == 32'd0) && (b_r != 32'd1)) ? 32'd0 : a_r;
      default:    res_nxt = 32'd0;
    endcase
  end

  assign status.opcode   = op_r;
  assign status.a_zero   = (a_r == 32'd0);
  assign status.b_zero   = (b_r == 32'd0);
  assign status.pow_triv = (b_r == 32'd0) || (b_r == 32'd1) || (a_r == 32'd0) || b_r[31];

  assign res_item.result         = res_nxt;
  assign res_item.divide_by_zero = dz_nxt;

endmodule

@@ rtl/integer_alu_div_mod_pow_unit.sv @@
// Top level of the microcoded 32-bit integer ALU with divide, remainder and power.
//
// The input channel (in_valid, in_stall, in_data) carries an opcode and two
// signed 32-bit operands; the result channel (out_valid, out_stall, out_data)
// returns one wrapped 32-bit result and a divide-by-zero flag per item.
// A transfer happens on a rising edge with valid high and stall low.
// One item is worked on at a time; in_stall is high while the sequencer runs.
// Microcode steps per item: add, subtract, multiply and unused opcodes run
// dispatch and then the operation; divide and remainder run one shift-subtract
// step per dividend bit plus dispatch, checks, setup and sign fix; power runs 31
// square-and-multiply steps plus dispatch, check, setup and result; a zero dividend,
// a zero divisor, a zero base and trivial exponents end after their checks.
// in_stall drops at the same edge that registers the result, so the unit can
// take a new item while that result still waits in the output register.
// A finished result waits in the output register while out_stall is high;
// the sequencer holds on its final step until the register can take it.
// Synchronous reset clears the sequencer and the output valid flag.
module integer_alu_div_mod_pow_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  iadp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output iadp_pkg::out_item_t  out_data
);
  import iadp_pkg::*;

  `include "integer_alu_div_mod_pow_unit_assert.svh"

  logic      busy;
  logic      start;
  logic      hold;
  logic      fire;
  ctrl_t     ctrl;
  status_t   status;
  out_item_t res_item;
  logic      out_valid_r;
  out_item_t out_data_r;

  assign in_stall = busy;
  assign start    = in_valid && !busy;
  assign hold     = out_valid_r && out_stall;
  assign fire     = ctrl.exec && ctrl.done;

  iadp_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .hold   (hold),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  iadp_dp u_dp (
    .clk      (clk),
    .load     (start),
    .in_item  (in_data),
    .ctrl     (ctrl),
    .status   (status),
    .res_item (res_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      out_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `IADP_ASSERT_NEXT(a_start_busy, clk, rst_n, start, busy)
  `IADP_ASSERT_IMP(a_no_overwrite, clk, rst_n, fire, !(out_valid_r && out_stall))
  `IADP_ASSERT_IMP(a_dz_zero, clk, rst_n, out_valid && out_data.divide_by_zero, ~|out_data.result)
  `IADP_ASSERT_IMP(a_fire_busy, clk, rst_n, ctrl.exec, busy)

endmodule

@@ tb/tb_integer_alu_div_mod_pow_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the integer ALU with add, subtract, multiply, divide, remainder and power.
module tb_integer_alu_div_mod_pow_unit;
  import iadp_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7fff_ffff;
  localparam int RANDOM_OPS = 600;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 50;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  in_item_t ops_to_send[$];
  out_item_t results_due[$];
  out_item_t due_result;
  int ops_total = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int idle_cycles = 0;

  wire in_fire = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  integer_alu_div_mod_pow_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  function automatic logic [31:0] wrapped_power(logic [31:0] base, logic [31:0] expo);
    logic [31:0] acc;
    logic [31:0] sq;
    int i;
    if (expo == 32'd0) return 32'd1;
    if (expo == 32'd1) return base;
    if (base == 32'd0) return 32'd0;
    if (expo[31]) return base;
    acc = 32'd1;
    sq = base;
    for (i = 0; i < 31; i++) begin
      if (expo[i]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  function automatic out_item_t alu_outcome(in_item_t item);
    out_item_t o;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] part;
    a = item.operand_a;
    b = item.operand_b;
    o = '0;
    case (item.opcode)
      OP_ADD: o.result = a + b;
      OP_SUB: o.result = a - b;
      OP_MUL: o.result = a * b;
      OP_DIV, OP_REM: begin
        if (a == 32'd0) begin
          o.result = '0;
        end else if (b == 32'd0) begin
          o.divide_by_zero = 1'b1;
        end else begin
          mag_a = a[31] ? -a : a;
          mag_b = b[31] ? -b : b;
          if (item.opcode == OP_DIV) begin
            part = mag_a / mag_b;
            o.result = (a[31] ^ b[31]) ? -part : part;
          end else begin
            part = mag_a % mag_b;
            o.result = a[31] ? -part : part;
          end
        end
      end
      OP_POW: o.result = wrapped_power(a, b);
      default: o.result = '0;
    endcase
    return o;
  endfunction

  function automatic in_item_t make_op(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    in_item_t item;
    item.opcode = op;
    item.operand_a = a;
    item.operand_b = b;
    return item;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 6))
          0: return 32'd0;
          1: return 32'd1;
          2: return -32'd1;
          3: return MOST_NEG;
          4: return MOST_POS;
          5: return 32'd2;
          default: return -32'd2;
        endcase
      end
      1: return 32'($urandom_range(0, 32)) - 32'd16;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 3));
      1: return 32'($urandom_range(0, 40));
      2: return pick_operand();
      default: return $urandom();
    endcase
  endfunction

  function automatic int pause_for(int count);
    return ((count / 40) % 3 == 2) ? 0 : int'($urandom_range(0, 19));
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    int n;
    logic [2:0] op;
    logic [31:0] a;
    ops_to_send.push_back(make_op(OP_ADD, MOST_POS, 32'd1));
    ops_to_send.push_back(make_op(OP_ADD, MOST_NEG, -32'd1));
    ops_to_send.push_back(make_op(OP_SUB, MOST_NEG, 32'd1));
    ops_to_send.push_back(make_op(OP_SUB, 32'd0, MOST_NEG));
    ops_to_send.push_back(make_op(OP_MUL, MOST_POS, MOST_POS));
    ops_to_send.push_back(make_op(OP_MUL, MOST_NEG, -32'd1));
    ops_to_send.push_back(make_op(OP_DIV, 32'd0, 32'd0));
    ops_to_send.push_back(make_op(OP_REM, 32'd0, 32'd0));
    ops_to_send.push_back(make_op(OP_DIV, 32'd7, 32'd0));
    ops_to_send.push_back(make_op(OP_REM, -32'd7, 32'd0));
    ops_to_send.push_back(make_op(OP_DIV, MOST_NEG, -32'd1));
    ops_to_send.push_back(make_op(OP_REM, MOST_NEG, -32'd1));
    ops_to_send.push_back(make_op(OP_DIV, -32'd7, 32'd2));
    ops_to_send.push_back(make_op(OP_REM, -32'd7, 32'd2));
    ops_to_send.push_back(make_op(OP_DIV, MOST_POS, -32'd2));
    ops_to_send.push_back(make_op(OP_REM, 32'd7, -32'd2));
    ops_to_send.push_back(make_op(OP_POW, 32'd0, 32'd0));
    ops_to_send.push_back(make_op(OP_POW, -32'd3, 32'd1));
    ops_to_send.push_back(make_op(OP_POW, 32'd0, 32'd5));
    ops_to_send.push_back(make_op(OP_POW, 32'd0, -32'd3));
    ops_to_send.push_back(make_op(OP_POW, 32'd3, -32'd2));
    ops_to_send.push_back(make_op(OP_POW, 32'd3, 32'd19));
    ops_to_send.push_back(make_op(OP_POW, -32'd1, MOST_POS));
    ops_to_send.push_back(make_op(OP_POW, 32'd2, 32'd31));
    ops_to_send.push_back(make_op(OP_SPARE_LO, MOST_POS, 32'd0));
    ops_to_send.push_back(make_op(OP_SPARE_HI, MOST_NEG, 32'd0));
    for (n = 0; n < RANDOM_OPS; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      end else begin
        op = 3'($urandom_range(OP_ADD, OP_POW));
      end
      a = pick_operand();
      ops_to_send.push_back(make_op(op, a, (op == OP_POW) ? pick_exponent() : pick_operand()));
    end
    ops_total = ops_to_send.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (ops_sent < ops_total) @(posedge clk);
    while (results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Driver: each transfer records its expected result, then a random gap precedes the next item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        results_due.push_back(alu_outcome(in_data));
        ops_sent++;
      end
      if (!in_valid || in_fire) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (ops_to_send.size() > 0) begin
          in_data <= ops_to_send.pop_front();
          in_valid <= 1'b1;
          send_wait = pause_for(ops_sent);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transfer with the oldest expectation and stalls at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_fire) begin
        if (results_due.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("Unexpected result: result %h divide_by_zero %b",
                     out_data.result, out_data.divide_by_zero);
          end
          mismatches++;
        end else begin
          due_result = results_due.pop_front();
          if (out_data.result !== due_result.result ||
              out_data.divide_by_zero !== due_result.divide_by_zero) begin
            if (mismatches < MAX_REPORTS) begin
              $display("Mismatch on result %0d: expected %h/%b, got %h/%b", results_seen,
                       due_result.result, due_result.divide_by_zero,
                       out_data.result, out_data.divide_by_zero);
            end
            mismatches++;
          end
        end
        results_seen++;
        recv_wait = pause_for(results_seen);
        out_stall <= (recv_wait != 0);
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= (recv_wait != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire || out_fire) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
